### sv/lv3_pkg.sv
// Shared types and constants for the 3D line voxel stepper.
// No dependencies; every other file in sv/ imports this package.
`timescale 1ns / 1ps

package lv3_pkg;

  // Port width of one coordinate field.
  localparam int CW = 6;
  // Error terms: twice a length minus a length, kept signed with headroom.
  localparam int EW = CW + 3;

  typedef logic [CW-1:0]        coord_t;
  typedef logic signed [EW-1:0] err_t;
  typedef logic [1:0]           axis_t;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  // Per-line plan, set up once and then held while the line is walked.
  typedef struct packed {
    axis_t      mj;
    axis_t      ma;
    axis_t      mb;
    logic [2:0] neg;
    coord_t     len_mj;
    err_t       two_mj;
    err_t       two_a;
    err_t       two_b;
    err_t       err_a;
    err_t       err_b;
  } plan_t;

endpackage

### sv/lv3_setup.sv
// Line set-up: axis deltas, step directions, dominant axis and initial errors.
// Depends on lv3_pkg.
`timescale 1ns / 1ps

module lv3_setup (
  input  lv3_pkg::coord_t [2:0] start_i,
  input  lv3_pkg::coord_t [2:0] end_i,
  output lv3_pkg::plan_t        plan_o
);
  import lv3_pkg::*;

  coord_t [2:0] len;
  logic   [2:0] neg;
  coord_t       len_mj;
  coord_t       len_a;
  coord_t       len_b;

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    assign neg[ax] = end_i[ax] < start_i[ax];
    assign len[ax] = neg[ax] ? (start_i[ax] - end_i[ax]) : (end_i[ax] - start_i[ax]);
  end

  always_comb begin
    plan_o = '0;
    // ties go to x, then y
    if (len[AX_X] >= len[AX_Y] && len[AX_X] >= len[AX_Z]) begin
      plan_o.mj = AX_X;
      plan_o.ma = AX_Y;
      plan_o.mb = AX_Z;
      len_mj    = len[AX_X];
      len_a     = len[AX_Y];
      len_b     = len[AX_Z];
    end else if (len[AX_Y] >= len[AX_Z]) begin
      plan_o.mj = AX_Y;
      plan_o.ma = AX_X;
      plan_o.mb = AX_Z;
      len_mj    = len[AX_Y];
      len_a     = len[AX_X];
      len_b     = len[AX_Z];
    end else begin
      plan_o.mj = AX_Z;
      plan_o.ma = AX_Y;
      plan_o.mb = AX_X;
      len_mj    = len[AX_Z];
      len_a     = len[AX_Y];
      len_b     = len[AX_X];
    end
    plan_o.neg    = neg;
    plan_o.len_mj = len_mj;
    plan_o.two_mj = $signed({2'b00, len_mj, 1'b0});
    plan_o.two_a  = $signed({2'b00, len_a, 1'b0});
    plan_o.two_b  = $signed({2'b00, len_b, 1'b0});
    plan_o.err_a  = plan_o.two_a - $signed({3'b000, len_mj});
    plan_o.err_b  = plan_o.two_b - $signed({3'b000, len_mj});
  end

endmodule

### sv/lv3_step.sv
// Step unit: advances the current voxel by one major-axis step, steps each minor
// axis whose error term is positive and updates both minor-axis error terms. Depends on lv3_pkg.
`timescale 1ns / 1ps

module lv3_step (
  input  lv3_pkg::plan_t        plan_i,
  input  lv3_pkg::coord_t [2:0] pt_i,
  input  lv3_pkg::err_t         err_a_i,
  input  lv3_pkg::err_t         err_b_i,
  output lv3_pkg::coord_t [2:0] pt_o,
  output lv3_pkg::err_t         err_a_o,
  output lv3_pkg::err_t         err_b_o
);
  import lv3_pkg::*;

  logic       step_a;
  logic       step_b;
  logic [2:0] adv;

  assign step_a = err_a_i > err_t'(0);
  assign step_b = err_b_i > err_t'(0);

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    assign adv[ax] = (plan_i.mj == axis_t'(ax))
                   | (step_a && plan_i.ma == axis_t'(ax))
                   | (step_b && plan_i.mb == axis_t'(ax));
    assign pt_o[ax] = !adv[ax]        ? pt_i[ax] :
                      plan_i.neg[ax]  ? pt_i[ax] - coord_t'(1) :
                                        pt_i[ax] + coord_t'(1);
  end

  assign err_a_o = err_a_i - (step_a ? plan_i.two_mj : err_t'(0)) + plan_i.two_a;
  assign err_b_o = err_b_i - (step_b ? plan_i.two_mj : err_t'(0)) + plan_i.two_b;

endmodule

### sv/line_voxel_stepper_3d_top.sv
// Top level of the 3D line voxel stepper: sequencer, line registers, output word.
// Depends on lv3_pkg, lv3_setup and lv3_step.
`timescale 1ns / 1ps

// Usage:
//   A request (start voxel, end voxel, mark) is taken at a rising edge with
//   start high and busy low. busy then stays high until the sequencer has
//   issued the last voxel of the line.
//   Each voxel comes out as one word on point_*_o / mark_o / last_point_o,
//   valid for exactly one cycle while point_valid_o is high. last_point_o
//   marks the end voxel. The receiver cannot stall; words must be taken as
//   they come.
//   Timing: the cycle after acceptance sets the line up; the single step unit
//   then walks one voxel a cycle, N+1 voxels for a largest axis delta of N,
//   and each word shows in the cycle after its step, so the first word
//   follows the set-up and the first step. busy stays high through both and
//   drops in the cycle the last word shows, when a new request may already be
//   accepted; no request is taken while a line is being walked.
//   Coordinate bits above COORD_BITS are ignored.
//   Reset clears the sequencer and the output strobe; nothing else is kept
//   between requests.

module line_voxel_stepper_3d_top #(
  parameter int COORD_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lv3_pkg::coord_t     start_x_i,
  input  lv3_pkg::coord_t     start_y_i,
  input  lv3_pkg::coord_t     start_z_i,
  input  lv3_pkg::coord_t     end_x_i,
  input  lv3_pkg::coord_t     end_y_i,
  input  lv3_pkg::coord_t     end_z_i,
  input  logic [7:0]          mark_value_i,
  output logic                point_valid_o,
  output lv3_pkg::coord_t     point_x_o,
  output lv3_pkg::coord_t     point_y_o,
  output lv3_pkg::coord_t     point_z_o,
  output logic [7:0]          mark_o,
  output logic                last_point_o
);
  import lv3_pkg::*;

  localparam int unsigned MaskInt   = (1 << COORD_BITS) - 1;
  localparam coord_t      CoordMask = coord_t'(MaskInt);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  state_e       state_q;
  coord_t [2:0] start_q;
  coord_t [2:0] end_q;
  logic   [7:0] mark_q;
  plan_t        plan_q;
  coord_t [2:0] pt_q;
  err_t         err_a_q;
  err_t         err_b_q;
  coord_t       cnt_q;
  logic         valid_q;
  coord_t [2:0] out_pt_q;
  logic   [7:0] out_mark_q;
  logic         last_q;

  plan_t        plan_d;
  coord_t [2:0] pt_d;
  err_t         err_a_d;
  err_t         err_b_d;

  lv3_setup u_setup (
    .start_i (start_q),
    .end_i   (end_q),
    .plan_o  (plan_d)
  );

  lv3_step u_step (
    .plan_i  (plan_q),
    .pt_i    (pt_q),
    .err_a_i (err_a_q),
    .err_b_i (err_b_q),
    .pt_o    (pt_d),
    .err_a_o (err_a_d),
    .err_b_o (err_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            start_q <= {start_z_i & CoordMask, start_y_i & CoordMask,
                        start_x_i & CoordMask};
            end_q   <= {end_z_i & CoordMask, end_y_i & CoordMask,
                        end_x_i & CoordMask};
            mark_q  <= mark_value_i;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          plan_q  <= plan_d;
          pt_q    <= start_q;
          err_a_q <= plan_d.err_a;
          err_b_q <= plan_d.err_b;
          cnt_q   <= plan_d.len_mj;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          valid_q    <= 1'b1;
          out_pt_q   <= pt_q;
          out_mark_q <= mark_q;
          last_q     <= (cnt_q == '0);
          if (cnt_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            pt_q    <= pt_d;
            err_a_q <= err_a_d;
            err_b_q <= err_b_d;
            cnt_q   <= cnt_q - coord_t'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign point_valid_o = valid_q;
  assign point_x_o     = out_pt_q[AX_X];
  assign point_y_o     = out_pt_q[AX_Y];
  assign point_z_o     = out_pt_q[AX_Z];
  assign mark_o        = out_mark_q;
  assign last_point_o  = last_q;

endmodule

### sv/lv3_chk.sv
// Port-level checker for the 3D line voxel stepper, bound to the top level.
// Depends on lv3_pkg and line_voxel_stepper_3d_top.
`timescale 1ns / 1ps

module lv3_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            point_valid_o,
  input logic [7:0]      mark_o,
  input logic            last_point_o
);
  import lv3_pkg::*;

  // an accepted request keeps the block busy for set-up
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepting a request");

  // words of one line come back to back until the last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !last_point_o |=> point_valid_o)
    else $error("gap inside a line");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !last_point_o |-> busy)
    else $error("line word while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && last_point_o |-> !busy)
    else $error("busy still high on the last word");

  // mark is constant along a line
  a_mark_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !last_point_o |=> mark_o == $past(mark_o))
    else $error("mark changed inside a line");

endmodule

bind line_voxel_stepper_3d_top lv3_chk u_lv3_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .point_valid_o (point_valid_o),
  .mark_o        (mark_o),
  .last_point_o  (last_point_o)
);

### sim/tb_line_voxel_stepper_3d_top.sv
// Self-checking testbench for line_voxel_stepper_3d_top: drives line requests and
// checks every emitted voxel word against a built-in 3D line tracer.
// Depends on lv3_pkg and the top level in sv/.
`timescale 1ns / 1ps

module tb_line_voxel_stepper_3d_top;
  import lv3_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic [7:0] mark;
    logic       last;
  } voxel_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  coord_t     start_x_i = '0;
  coord_t     start_y_i = '0;
  coord_t     start_z_i = '0;
  coord_t     end_x_i = '0;
  coord_t     end_y_i = '0;
  coord_t     end_z_i = '0;
  logic [7:0] mark_value_i = '0;
  logic       point_valid_o;
  coord_t     point_x_o;
  coord_t     point_y_o;
  coord_t     point_z_o;
  logic [7:0] mark_o;
  logic       last_point_o;

  voxel_t pending_voxels[$];
  int     mismatches = 0;
  int     cycles = 0;

  line_voxel_stepper_3d_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .start_z_i     (start_z_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .end_z_i       (end_z_i),
    .mark_value_i  (mark_value_i),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .mark_o        (mark_o),
    .last_point_o  (last_point_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL line_voxel_stepper_3d_top");
      $finish;
    end
  end

  // Walks the line the same way the block does and queues one word per voxel.
  function automatic void trace_line(coord_t sx, coord_t sy, coord_t sz,
                                     coord_t ex, coord_t ey, coord_t ez,
                                     logic [7:0] mv);
    int     pos[3];
    int     span[3];
    int     dir[3];
    int     s[3];
    int     e[3];
    axis_t  major;
    axis_t  mina;
    axis_t  minb;
    int     two_major;
    int     two_a;
    int     two_b;
    int     err_a;
    int     err_b;
    voxel_t v;
    s = '{int'(sx), int'(sy), int'(sz)};
    e = '{int'(ex), int'(ey), int'(ez)};
    for (int ax = 0; ax < 3; ax++) begin
      pos[ax]  = s[ax];
      dir[ax]  = (e[ax] < s[ax]) ? -1 : 1;
      span[ax] = (e[ax] < s[ax]) ? s[ax] - e[ax] : e[ax] - s[ax];
    end
    // ties prefer x, then y
    if (span[AX_X] >= span[AX_Y] && span[AX_X] >= span[AX_Z]) begin
      major = AX_X; mina = AX_Y; minb = AX_Z;
    end else if (span[AX_Y] >= span[AX_Z]) begin
      major = AX_Y; mina = AX_X; minb = AX_Z;
    end else begin
      major = AX_Z; mina = AX_Y; minb = AX_X;
    end
    two_major = 2 * span[major];
    two_a     = 2 * span[mina];
    two_b     = 2 * span[minb];
    err_a     = two_a - span[major];
    err_b     = two_b - span[major];
    for (int i = 0; i <= span[major]; i++) begin
      v.x    = coord_t'(pos[AX_X]);
      v.y    = coord_t'(pos[AX_Y]);
      v.z    = coord_t'(pos[AX_Z]);
      v.mark = mv;
      v.last = (i == span[major]);
      pending_voxels.push_back(v);
      if (err_a > 0) begin
        pos[mina] += dir[mina];
        err_a     -= two_major;
      end
      if (err_b > 0) begin
        pos[minb] += dir[minb];
        err_b     -= two_major;
      end
      err_a      += two_a;
      err_b      += two_b;
      pos[major] += dir[major];
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    voxel_t want;
    if (rst_ni && point_valid_o) begin
      if (pending_voxels.size() == 0) begin
        $error("voxel word with none expected: (%0d,%0d,%0d) mark %0d last %0b",
               point_x_o, point_y_o, point_z_o, mark_o, last_point_o);
        mismatches++;
      end else begin
        want = pending_voxels.pop_front();
        check_field("point_x", want.x, point_x_o);
        check_field("point_y", want.y, point_y_o);
        check_field("point_z", want.z, point_z_o);
        check_field("mark", want.mark, mark_o);
        check_field("last_point", want.last, last_point_o);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  // Random coordinate within a few voxels of a base, for short lines.
  function automatic coord_t near(coord_t base);
    int lo;
    int hi;
    lo = (int'(base) < 7) ? 0 : int'(base) - 7;
    hi = (int'(base) > 56) ? 63 : int'(base) + 7;
    return coord_t'($urandom_range(lo, hi));
  endfunction

  // Presents one request and holds it until taken; start stays high when gap is 0
  // so the next request follows back to back.
  task automatic send_line(coord_t sx, coord_t sy, coord_t sz,
                           coord_t ex, coord_t ey, coord_t ez,
                           logic [7:0] mv, int gap);
    @(negedge clk_i);
    start        <= 1'b1;
    start_x_i    <= sx;
    start_y_i    <= sy;
    start_z_i    <= sz;
    end_x_i      <= ex;
    end_y_i      <= ey;
    end_z_i      <= ez;
    mark_value_i <= mv;
    do @(posedge clk_i); while (busy);
    trace_line(sx, sy, sz, ex, ey, ez, mv);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_line(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 8'd0, pick_gap());
    send_line(6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 8'd255, pick_gap());
    send_line(6'd17, 6'd42, 6'd5, 6'd17, 6'd42, 6'd5, 8'h5a, 0);
    send_line(6'd0, 6'd0, 6'd0, 6'd63, 6'd0, 6'd0, 8'h01, pick_gap());
    send_line(6'd63, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0, 8'h80, pick_gap());
    send_line(6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 6'd63, 8'h7f, pick_gap());
    send_line(6'd10, 6'd0, 6'd20, 6'd13, 6'd63, 6'd24, 8'h33, 0);
    send_line(6'd30, 6'd40, 6'd0, 6'd25, 6'd33, 6'd63, 8'hcc, pick_gap());
    // equal spans: x wins over y and z, y wins over z
    send_line(6'd0, 6'd0, 6'd5, 6'd9, 6'd9, 6'd7, 8'h11, pick_gap());
    send_line(6'd4, 6'd0, 6'd0, 6'd6, 6'd12, 6'd12, 8'h22, pick_gap());
    send_line(6'd20, 6'd3, 6'd20, 6'd8, 6'd1, 6'd32, 8'h44, 0);
    send_line(6'd0, 6'd63, 6'd0, 6'd63, 6'd0, 6'd63, 8'haa, pick_gap());
    send_line(6'd50, 6'd50, 6'd50, 6'd49, 6'd51, 6'd50, 8'h55, pick_gap());
    send_line(6'd63, 6'd0, 6'd63, 6'd21, 6'd31, 6'd2, 8'hfe, pick_gap());
    send_line(6'd1, 6'd62, 6'd32, 6'd2, 6'd61, 6'd31, 8'h99, pick_gap());
  endtask

  task automatic test_back_to_back();
    coord_t sx;
    coord_t sy;
    coord_t sz;
    for (int i = 0; i < 12; i++) begin
      sx = coord_t'($urandom_range(0, 63));
      sy = coord_t'($urandom_range(0, 63));
      sz = coord_t'($urandom_range(0, 63));
      // include single-voxel lines so a new word starts right after a short one
      if (i % 3 == 0)
        send_line(sx, sy, sz, sx, sy, sz, 8'($urandom), 0);
      else
        send_line(sx, sy, sz, near(sx), near(sy), near(sz), 8'($urandom), 0);
    end
  endtask

  task automatic test_random_lines(int count);
    coord_t sx;
    coord_t sy;
    coord_t sz;
    bit     dense;
    int     gap;
    dense = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) dense = ($urandom_range(0, 2) == 0);
      gap = dense ? 0 : pick_gap();
      sx = coord_t'($urandom_range(0, 63));
      sy = coord_t'($urandom_range(0, 63));
      sz = coord_t'($urandom_range(0, 63));
      if ($urandom_range(0, 3) == 0)
        send_line(sx, sy, sz, coord_t'($urandom_range(0, 63)),
                  coord_t'($urandom_range(0, 63)), coord_t'($urandom_range(0, 63)),
                  8'($urandom), gap);
      else
        send_line(sx, sy, sz, near(sx), near(sy), near(sz), 8'($urandom), gap);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_back_to_back();
    test_random_lines(133);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_voxels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_voxels.size() == 0) begin
      $display("PASS line_voxel_stepper_3d_top");
    end else begin
      $display("FAIL line_voxel_stepper_3d_top");
    end
    $finish;
  end

endmodule
